// File: rtl/core/modinv_pkg.sv
package modinv_pkg;

   // Default operand width in bits.
   localparam int WIDTH_DEFAULT = 63;

   // Sequencer of the Euclid engine.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_GROW,
      ST_SHRINK,
      ST_FINISH
   } state_type;

   // From the top level to the engine.
   typedef struct packed {
      logic start;   // an input transfer is taking place
      logic taken;   // the output register can take the result this cycle
   } ctrl_type;

   // From the engine to the top level.
   typedef struct packed {
      logic idle;    // ready for a new operand pair
      logic done;    // the result on the inverse bus is final
   } status_type;

endpackage

// File: rtl/core/modinv_core.sv
module modinv_core #(
   parameter int WIDTH = modinv_pkg::WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  modinv_pkg::ctrl_type   ctrl,
   input  logic [WIDTH-1:0]       value,
   input  logic [WIDTH-1:0]       modulus,
   output modinv_pkg::status_type status,
   output logic [WIDTH-1:0]       inverse
);

   // Coefficients stay within twice the modulus in magnitude, plus a sign bit.
   localparam int SW = WIDTH + 2;
   localparam int KW = $clog2(WIDTH);

   modinv_pkg::state_type state_ff, state_in;

   logic [WIDTH-1:0]        n_ff;     // modulus, kept for the final correction
   logic [WIDTH-1:0]        r1_ff;    // divisor of the current quotient step
   logic signed [SW-1:0]    s0_ff;    // coefficient belonging to the dividend
   logic signed [SW-1:0]    s1_ff;    // coefficient belonging to the divisor
   logic [WIDTH-1:0]        rem_ff;   // partial remainder of the current step
   logic signed [SW-1:0]    sacc_ff;  // s0 minus the partial quotient times s1
   logic [WIDTH-1:0]        d_ff;     // divisor shifted left by k
   logic signed [SW-1:0]    m_ff;     // s1 shifted left by k
   logic [KW-1:0]           k_ff;

   logic                    grow_fits;
   logic                    shrink_fits;
   logic [WIDTH-1:0]        rem_next;
   logic signed [SW-1:0]    sacc_next;

   logic                    load;
   logic                    grow_step;
   logic                    shrink_step;
   logic                    step_end;

   // Shared compare and subtract unit.
   always_comb begin
      grow_fits   = {d_ff, 1'b0} <= {1'b0, rem_ff};
      shrink_fits = d_ff <= rem_ff;
      rem_next    = shrink_fits ? rem_ff - d_ff : rem_ff;
      sacc_next   = shrink_fits ? sacc_ff - m_ff : sacc_ff;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         modinv_pkg::ST_IDLE: begin
            if (ctrl.start) begin
               state_in = (modulus == '0) ? modinv_pkg::ST_FINISH : modinv_pkg::ST_GROW;
            end
         end
         modinv_pkg::ST_GROW: begin
            if (!grow_fits) begin
               state_in = modinv_pkg::ST_SHRINK;
            end
         end
         modinv_pkg::ST_SHRINK: begin
            if (k_ff == '0) begin
               state_in = (rem_next == '0) ? modinv_pkg::ST_FINISH : modinv_pkg::ST_GROW;
            end
         end
         modinv_pkg::ST_FINISH: begin
            if (ctrl.taken) begin
               state_in = modinv_pkg::ST_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      load        = (state_ff == modinv_pkg::ST_IDLE) && ctrl.start;
      grow_step   = (state_ff == modinv_pkg::ST_GROW) && grow_fits;
      shrink_step = (state_ff == modinv_pkg::ST_SHRINK);
      step_end    = shrink_step && (k_ff == '0);
      status.idle = (state_ff == modinv_pkg::ST_IDLE);
      status.done = (state_ff == modinv_pkg::ST_FINISH);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= modinv_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         n_ff    <= modulus;
         r1_ff   <= modulus;
         s0_ff   <= SW'(1);
         s1_ff   <= '0;
         rem_ff  <= value;
         sacc_ff <= SW'(1);
         d_ff    <= modulus;
         m_ff    <= '0;
         k_ff    <= '0;
      end else if (grow_step) begin
         d_ff <= d_ff << 1;
         m_ff <= m_ff <<< 1;
         k_ff <= k_ff + KW'(1);
      end else if (step_end) begin
         // Quotient step complete: the divisor becomes the next dividend.
         r1_ff   <= rem_next;
         s0_ff   <= s1_ff;
         s1_ff   <= sacc_next;
         rem_ff  <= r1_ff;
         sacc_ff <= s1_ff;
         d_ff    <= rem_next;
         m_ff    <= sacc_next;
         k_ff    <= '0;
      end else if (shrink_step) begin
         rem_ff  <= rem_next;
         sacc_ff <= sacc_next;
         d_ff    <= d_ff >> 1;
         m_ff    <= m_ff >>> 1;
         k_ff    <= k_ff - KW'(1);
      end
   end

   // The final coefficient lies strictly between minus and plus the modulus.
   always_comb begin
      if (n_ff == '0) begin
         inverse = '0;
      end else if (s0_ff[SW-1]) begin
         inverse = n_ff + s0_ff[WIDTH-1:0];
      end else begin
         inverse = s0_ff[WIDTH-1:0];
      end
   end

endmodule

// File: rtl/core/modular_inverse_unit.sv
// Modular inverse unit, extended Euclidean algorithm.
//
// The request channel carries a value and a modulus; the response channel
// returns the Bezout coefficient of the value reduced into 0..modulus-1, which
// is the modular inverse when the two are coprime. Coprimality is not checked.
// A modulus of zero or one returns zero.
//
// One operand pair is worked on at a time. Each Euclid quotient step runs on a
// single shared compare and subtract unit: the divisor is doubled as long as
// its double does not pass the remainder, then halved back while conditional
// subtractions form the remainder and the new coefficient. req_tready is low
// for the whole time that a pair is being worked on.
//
// The result sits in an output register, so the next pair is accepted while a
// result still waits for rsp_tready. If the receiver stalls longer, the engine
// holds its finished result and stays busy until the register frees up.
// Reset is synchronous and leaves the unit idle with no response pending.
module modular_inverse_unit #(
   parameter int WIDTH = modinv_pkg::WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // Fields from bit 0 up: value, modulus, zero fill to whole bytes.
   input  logic [((2 * WIDTH + 7) / 8) * 8 - 1:0] req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // Fields from bit 0 up: inverse, zero fill to whole bytes.
   output logic [((WIDTH + 7) / 8) * 8 - 1:0]     rsp_tdata
);

   localparam int RSP_W = ((WIDTH + 7) / 8) * 8;

   modinv_pkg::ctrl_type   ctrl;
   modinv_pkg::status_type status;

   logic [WIDTH-1:0] value;
   logic [WIDTH-1:0] modulus;
   logic [WIDTH-1:0] inverse;

   logic             rsp_tvalid_ff, rsp_tvalid_in;
   logic [WIDTH-1:0] inverse_ff, inverse_in;

   assign value   = req_tdata[WIDTH-1:0];
   assign modulus = req_tdata[2*WIDTH-1:WIDTH];

   assign req_tready = status.idle;

   // The output register can load whenever it is empty or being drained.
   always_comb begin
      ctrl.start = req_tvalid && status.idle;
      ctrl.taken = !rsp_tvalid_ff || rsp_tready;
   end

   modinv_core #(
      .WIDTH (WIDTH)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ctrl),
      .value   (value),
      .modulus (modulus),
      .status  (status),
      .inverse (inverse)
   );

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      inverse_in    = inverse_ff;
      if (ctrl.taken) begin
         rsp_tvalid_in = status.done;
         if (status.done) begin
            inverse_in = inverse;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      inverse_ff <= inverse_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = RSP_W'(inverse_ff);

endmodule

// File: rtl/core/modinv_checker.sv
module modinv_checker #(
   parameter int WIDTH = modinv_pkg::WIDTH_DEFAULT
) (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_tvalid,
   input logic                                 req_tready,
   input logic [((2 * WIDTH + 7) / 8) * 8 - 1:0] req_tdata,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [((WIDTH + 7) / 8) * 8 - 1:0]     rsp_tdata
);

   // A stalled response keeps its data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // A waiting request keeps its data until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata))
      else $error("waiting request changed");

   // An accepted pair keeps the unit busy for at least the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("unit ready right after a request transfer");

   // Reset leaves the unit idle with no response pending.
   assert property (@(posedge clock)
      reset |=> req_tready && !rsp_tvalid)
      else $error("unit not idle after reset");

   // The fill bits above the result are zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata >> WIDTH) == '0)
      else $error("response fill bits not zero");

endmodule

bind modular_inverse_unit modinv_checker #(
   .WIDTH (WIDTH)
) u_modinv_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: bench/tb.sv
module tb;

   localparam int WIDTH = modinv_pkg::WIDTH_DEFAULT;
   localparam int REQ_BITS = ((2 * WIDTH + 7) / 8) * 8;
   localparam int RSP_BITS = ((WIDTH + 7) / 8) * 8;

   // Random transfers after the directed table.
   localparam int RANDOM_PAIRS = 700;
   // Cycles to keep watching for stray responses after the last expected one.
   localparam int DRAIN_CYCLES = 400;
   // Watchdog limit on the length of the whole run, in cycles.
   localparam int CYCLE_LIMIT = 1_200_000;
   localparam int MAX_GAP = 18;

   localparam logic [WIDTH-1:0] ALL_ONES = '1;
   localparam logic [WIDTH-1:0] FIB_91 = 63'd4660046610375530309;
   localparam logic [WIDTH-1:0] FIB_92 = 63'd7540113804746346429;

   // One pair in flight: its operands and the inverse the response must carry.
   typedef struct {
      logic [WIDTH-1:0] value;
      logic [WIDTH-1:0] modulus;
      logic [WIDTH-1:0] inverse;
   } inverse_entry_type;

   // A row of the directed table. When known is set, inverse is the typed-in answer;
   // otherwise the answer comes from the Euclid predictor below.
   typedef struct {
      logic [WIDTH-1:0] value;
      logic [WIDTH-1:0] modulus;
      bit               known;
      logic [WIDTH-1:0] inverse;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 20;

   directed_row_type directed_pairs [DIRECTED_ROWS] = '{
      // A modulus of one always reduces to zero, whatever the value.
      '{63'd0,                      63'd1,                      1'b1, 63'd0},
      '{ALL_ONES,                   63'd1,                      1'b1, 63'd0},
      // A zero value has a zero coefficient.
      '{63'd0,                      ALL_ONES,                   1'b1, 63'd0},
      // A zero modulus lies outside the legal range; the unit returns zero.
      '{63'd12345,                  63'd0,                      1'b1, 63'd0},
      '{63'd0,                      63'd0,                      1'b1, 63'd0},
      '{63'd1,                      ALL_ONES,                   1'b1, 63'd1},
      '{63'd1,                      63'd2,                      1'b1, 63'd1},
      // The inverse of minus one is minus one.
      '{ALL_ONES - 63'd1,           ALL_ONES,                   1'b1, ALL_ONES - 63'd1},
      '{63'd3,                      63'd7,                      1'b1, 63'd5},
      // Value above the modulus, reduced by the first quotient step.
      '{63'd10,                     63'd7,                      1'b0, 63'd0},
      // Common factors: the coefficient comes back, but it is no inverse.
      '{63'd6,                      63'd9,                      1'b0, 63'd0},
      '{ALL_ONES,                   ALL_ONES,                   1'b0, 63'd0},
      // Consecutive Fibonacci numbers give the longest quotient chain.
      '{FIB_91,                     FIB_92,                     1'b0, 63'd0},
      '{FIB_92,                     FIB_91,                     1'b0, 63'd0},
      '{ALL_ONES,                   63'd2,                      1'b0, 63'd0},
      '{63'h5555_5555_5555_5555,    63'h4000_0000_0000_0000,    1'b0, 63'd0},
      '{63'd2,                      ALL_ONES,                   1'b0, 63'd0},
      '{63'h2AAA_AAAA_AAAA_AAAB,    63'h7FFF_FFFF_FFFF_FFE7,    1'b0, 63'd0},
      '{ALL_ONES,                   63'h4000_0000_0000_0001,    1'b0, 63'd0},
      '{63'h0123_4567_89AB_CDEF,    63'h7EDC_BA98_7654_3211,    1'b0, 63'd0}
   };

   logic                clock;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [REQ_BITS-1:0] req_tdata = '0;   // value, modulus, zero fill
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_BITS-1:0] rsp_tdata;        // inverse, zero fill

   // Expected inverses, oldest first, one per accepted request transfer.
   inverse_entry_type inverse_queue [$];
   int                mismatch_count = 0;
   int                sent_count = 0;
   int                received_count = 0;
   int                cycle_count = 0;

   modular_inverse_unit #(.WIDTH(WIDTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Extended Euclid on 64-bit words that wrap, keeping only the coefficient of the
   // value. The coefficient is read as two's complement and folded into 0..modulus-1.
   function automatic logic [WIDTH-1:0] euclid_inverse(input logic [WIDTH-1:0] value,
                                                       input logic [WIDTH-1:0] modulus);
      logic [63:0] rem_prev;
      logic [63:0] rem_cur;
      logic [63:0] coef_prev;
      logic [63:0] coef_cur;
      logic [63:0] quotient;
      logic [63:0] scratch;
      logic [63:0] folded;
      int          step;
      if (modulus == '0) begin
         return '0;
      end
      rem_prev  = 64'(value);
      rem_cur   = 64'(modulus);
      coef_prev = 64'd1;
      coef_cur  = 64'd0;
      for (step = 0; step < 128 && rem_cur != 64'd0; step++) begin
         quotient  = rem_prev / rem_cur;
         scratch   = rem_prev - quotient * rem_cur;
         rem_prev  = rem_cur;
         rem_cur   = scratch;
         scratch   = coef_prev - quotient * coef_cur;
         coef_prev = coef_cur;
         coef_cur  = scratch;
      end
      if (coef_prev[63]) begin
         // Negative coefficient: reduce its magnitude, then take the complement mod n.
         folded = (64'd0 - coef_prev) % 64'(modulus);
         if (folded != 64'd0) begin
            folded = 64'(modulus) - folded;
         end
      end else begin
         folded = coef_prev % 64'(modulus);
      end
      return folded[WIDTH-1:0];
   endfunction

   // A random operand of at most the given number of significant bits (1 to 63).
   function automatic logic [WIDTH-1:0] random_operand(input int nbits);
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      if (nbits < 64) begin
         raw &= (64'd1 << nbits) - 64'd1;
      end
      return raw[WIDTH-1:0];
   endfunction

   // For 48 transfers out of every 192 both sides go quiet on idling, so the
   // unit also sees back-to-back pairs and a receiver that never stalls.
   function automatic bit calm_stretch(input int count);
      return (count / 48) % 4 == 1;
   endfunction

   task automatic report_mismatch(input string what, input inverse_entry_type entry,
                                  input logic [WIDTH-1:0] got);
      mismatch_count++;
      $display("MISMATCH %s: value=%h modulus=%h got=%h want=%h", what, entry.value,
               entry.modulus, got, entry.inverse);
   endtask

   // Presents one pair after a random gap and holds it until the transfer happens.
   // The valid is only lowered when a gap follows, so it never gets two updates in
   // one step. The expectation is queued at the accepting edge.
   task automatic send_pair(input logic [WIDTH-1:0] value, input logic [WIDTH-1:0] modulus,
                            input bit known, input logic [WIDTH-1:0] typed_inverse);
      int                gap;
      inverse_entry_type entry;
      gap = calm_stretch(sent_count) ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_BITS'({modulus, value});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      entry.value   = value;
      entry.modulus = modulus;
      entry.inverse = known ? typed_inverse : euclid_inverse(value, modulus);
      inverse_queue.push_back(entry);
      sent_count++;
   endtask

   // Response side: stalls a random number of cycles before each transfer, then takes
   // the response and compares it with the oldest expectation.
   initial begin : response_checker
      int                stall;
      inverse_entry_type entry;
      inverse_entry_type blank;
      logic [WIDTH-1:0]  got;
      blank = '{'0, '0, '0};
      wait (!reset);
      forever begin
         stall = calm_stretch(received_count) ? 0 : $urandom_range(0, MAX_GAP);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         got = rsp_tdata[WIDTH-1:0];
         received_count++;
         if (inverse_queue.size() == 0) begin
            report_mismatch("response with no request pending", blank, got);
         end else begin
            entry = inverse_queue.pop_front();
            if (got !== entry.inverse) begin
               report_mismatch("inverse", entry, got);
            end
         end
      end
   end

   // Watchdog: a hung handshake or a lost response ends the run here.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

   initial begin : stimulus
      int               row;
      int               pair;
      int               fib_index;
      int               k;
      logic [WIDTH-1:0] value;
      logic [WIDTH-1:0] modulus;
      logic [WIDTH-1:0] fib_lo;
      logic [WIDTH-1:0] fib_hi;
      logic [WIDTH-1:0] fib_next;

      // Synchronous reset, applied once.
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (row = 0; row < DIRECTED_ROWS; row++) begin
         send_pair(directed_pairs[row].value, directed_pairs[row].modulus,
                   directed_pairs[row].known, directed_pairs[row].inverse);
      end

      for (pair = 0; pair < RANDOM_PAIRS; pair++) begin
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               // Full-width operands, either one may be the larger.
               value   = random_operand(63);
               modulus = random_operand(63);
            end
            3, 4: begin
               // Mixed operand sizes, so quotient chains of every length occur.
               value   = random_operand($urandom_range(1, 63));
               modulus = random_operand($urandom_range(1, 63));
            end
            5: begin
               // Value strictly below a modulus of at least two, the usual way the unit is used.
               modulus = random_operand($urandom_range(2, 63));
               if (modulus < WIDTH'(2)) begin
                  modulus = WIDTH'(2);
               end
               value = random_operand(63) % modulus;
            end
            6: begin
               // Consecutive Fibonacci numbers: the most quotient steps for their size.
               fib_index = $urandom_range(2, 92);
               fib_lo = '0;
               fib_hi = WIDTH'(1);
               for (k = 1; k < fib_index; k++) begin
                  fib_next = fib_lo + fib_hi;
                  fib_lo   = fib_hi;
                  fib_hi   = fib_next;
               end
               if ($urandom_range(0, 1) == 1) begin
                  value   = fib_lo;
                  modulus = fib_hi;
               end else begin
                  value   = fib_hi;
                  modulus = fib_lo;
               end
            end
            7: begin
               // Power-of-two modulus; odd values are invertible, even ones are not.
               modulus = WIDTH'(64'd1 << $urandom_range(1, 62));
               value   = random_operand(63);
            end
            8: begin
               // Shared factors on purpose.
               k       = $urandom_range(2, 1000);
               value   = random_operand($urandom_range(1, 50)) * WIDTH'(k);
               modulus = random_operand($urandom_range(1, 50)) * WIDTH'(k);
            end
            default: begin
               // Edge operands: zero, one, the modulus itself, all ones.
               case ($urandom_range(0, 4))
                  0: value = '0;
                  1: value = WIDTH'(1);
                  2: value = ALL_ONES;
                  default: value = random_operand(63);
               endcase
               case ($urandom_range(0, 3))
                  0: modulus = WIDTH'(1);
                  1: modulus = ALL_ONES;
                  2: modulus = value;
                  default: modulus = random_operand($urandom_range(1, 63));
               endcase
            end
         endcase
         if (modulus == '0) begin
            modulus = WIDTH'(1);
         end
         send_pair(value, modulus, 1'b0, '0);
      end

      req_tvalid <= 1'b0;
      // Every pair yields exactly one response; wait for the last one, then watch a
      // while longer for anything extra.
      while (inverse_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// File: modular_inverse_unit.f
rtl/core/modinv_pkg.sv
rtl/core/modinv_core.sv
rtl/core/modular_inverse_unit.sv
rtl/core/modinv_checker.sv
bench/tb.sv
